// File: sv/gdg_pkg.sv
// Package for the 5x7 glyph dot generator: widths, codes, state type and font ROM.
// Used by glyph_dot_generator_5x7; no dependencies.

package gdg_pkg;

   localparam int GLYPH_COLUMNS = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int CELL_ADVANCE  = 6;
   localparam int DOT_COUNT     = GLYPH_COLUMNS * GLYPH_ROWS;

   localparam int CODE_W   = 8;
   localparam int COORD_W  = 16;
   localparam int COLOUR_W = 32;
   localparam int SCALE_W  = 5;
   localparam int OFFSET_W = 8;
   localparam int IDX_W    = $clog2(DOT_COUNT);
   localparam int ROW_W    = $clog2(GLYPH_ROWS);

   localparam int REQ_DATA_W = CODE_W + 2 * COORD_W + COLOUR_W;
   localparam int RSP_DATA_W = 2 * COORD_W + COLOUR_W;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd2;
   localparam logic [SCALE_W-1:0] SCALE_MIN   = 5'd1;
   localparam logic [SCALE_W-1:0] SCALE_MAX   = 5'd16;

   localparam int PEN_DEPTH  = 2;
   localparam int PEN_ADDR_W = 1;
   localparam logic [PEN_ADDR_W-1:0] PEN_X_ADDR = 1'b0;
   localparam logic [PEN_ADDR_W-1:0] PEN_Y_ADDR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_X,
      ST_LOAD_Y,
      ST_DRAW,
      ST_ADVANCE
   } state_type;

   typedef logic [DOT_COUNT-1:0] glyph_type;

   function automatic glyph_type pack_cols(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] c3,
                                           input logic [7:0] c4);
      return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
   endfunction

   function automatic glyph_type glyph_lookup(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] c;
      glyph_type         g;
      c = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         c = code - 8'h20;
      end
      unique case (c)
         8'h21:   g = pack_cols(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
         8'h2D:   g = pack_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
         8'h2E:   g = pack_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
         8'h2F:   g = pack_cols(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
         8'h30:   g = pack_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
         8'h31:   g = pack_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
         8'h32:   g = pack_cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
         8'h33:   g = pack_cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
         8'h34:   g = pack_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
         8'h35:   g = pack_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
         8'h36:   g = pack_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
         8'h37:   g = pack_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
         8'h38:   g = pack_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
         8'h39:   g = pack_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
         8'h3A:   g = pack_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
         8'h41:   g = pack_cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
         8'h42:   g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
         8'h43:   g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
         8'h44:   g = pack_cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
         8'h45:   g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
         8'h46:   g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h01, 8'h01);
         8'h47:   g = pack_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
         8'h48:   g = pack_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
         8'h49:   g = pack_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
         8'h4A:   g = pack_cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
         8'h4B:   g = pack_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
         8'h4C:   g = pack_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
         8'h4D:   g = pack_cols(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
         8'h4E:   g = pack_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
         8'h4F:   g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
         8'h50:   g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
         8'h51:   g = pack_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
         8'h52:   g = pack_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
         8'h53:   g = pack_cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
         8'h54:   g = pack_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
         8'h55:   g = pack_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
         8'h56:   g = pack_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
         8'h57:   g = pack_cols(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
         8'h58:   g = pack_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
         8'h59:   g = pack_cols(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
         8'h5A:   g = pack_cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// File: sv/gdg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module gdg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/glyph_dot_generator_5x7.sv
// 5x7 glyph dot generator: one character word in, one word per lit dot out.
// An item loads pen x, then pen y, from the two-entry pen RAM (ST_LOAD_X, ST_LOAD_Y;
// ST_LOAD_Y also writes pen y back), then walks the glyph positions up to the last lit
// dot (at most 35; none for a blank glyph; a lit dot waits while the output stalls),
// then writes back the advanced pen x. A new item is accepted only in ST_IDLE.
// Reset sets dot scale to 2; pen entries read as zero until first written.

module glyph_dot_generator_5x7 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gdg_pkg::SCALE_W-1:0]        csr_data,    // dot_scale
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // char_code, text_x, text_y, ink_colour
   input  logic [gdg_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,   // start_of_string
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // dot_x, dot_y, dot_colour
   output logic [gdg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast    // last_dot
);

   localparam int CW = gdg_pkg::COORD_W;
   localparam int OW = gdg_pkg::OFFSET_W;

   gdg_pkg::state_type                    state_ff, state_in;
   logic [gdg_pkg::SCALE_W-1:0]           scale_ff, scale_in;
   logic [gdg_pkg::PEN_DEPTH-1:0]         pen_valid_ff, pen_valid_in;
   logic                                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [CW-1:0]                         dot_x_ff, dot_x_in;
   logic [CW-1:0]                         dot_y_ff, dot_y_in;
   logic [gdg_pkg::COLOUR_W-1:0]          dot_colour_ff, dot_colour_in;
   logic                                  last_dot_ff, last_dot_in;
   gdg_pkg::glyph_type                    glyph_ff, glyph_in;
   logic [gdg_pkg::COLOUR_W-1:0]          colour_ff, colour_in;
   logic                                  sos_ff, sos_in;
   logic [CW-1:0]                         text_x_ff, text_x_in;
   logic [CW-1:0]                         text_y_ff, text_y_in;
   logic [CW-1:0]                         pen_x_ff, pen_x_in;
   logic [CW-1:0]                         pen_y_ff, pen_y_in;
   logic [gdg_pkg::IDX_W-1:0]             idx_ff, idx_in;
   logic [gdg_pkg::ROW_W-1:0]             row_ff, row_in;
   logic [OW-1:0]                         col_off_ff, col_off_in;
   logic [OW-1:0]                         row_off_ff, row_off_in;

   logic                                  ram_wr_en;
   logic [gdg_pkg::PEN_ADDR_W-1:0]        ram_wr_addr;
   logic [CW-1:0]                         ram_wr_data;
   logic [gdg_pkg::PEN_ADDR_W-1:0]        ram_rd_addr;
   logic [CW-1:0]                         ram_rd_data;

   logic [gdg_pkg::SCALE_W-1:0]           scale;
   logic [OW-1:0]                         advance;
   logic                                  out_free;
   logic                                  lit;
   logic                                  last;
   gdg_pkg::glyph_type                    above;
   logic [CW:0]                           sum_x;
   logic [CW:0]                           sum_y;
   logic [CW:0]                           sum_adv;

   gdg_ram #(
      .WIDTH (CW),
      .DEPTH (gdg_pkg::PEN_DEPTH)
   ) u_pen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == gdg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {dot_colour_ff, dot_y_ff, dot_x_ff};
   assign rsp_tlast  = last_dot_ff;

   always_comb begin
      if (scale_ff < gdg_pkg::SCALE_MIN) begin
         scale = gdg_pkg::SCALE_MIN;
      end else if (scale_ff > gdg_pkg::SCALE_MAX) begin
         scale = gdg_pkg::SCALE_MAX;
      end else begin
         scale = scale_ff;
      end
   end

   assign advance  = OW'(gdg_pkg::CELL_ADVANCE) * OW'(scale);
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign lit      = glyph_ff[idx_ff];
   assign above    = glyph_ff >> idx_ff;
   assign last     = (above[gdg_pkg::DOT_COUNT-1:1] == '0);
   assign sum_x    = {1'b0, pen_x_ff} + (CW+1)'(col_off_ff);
   assign sum_y    = {1'b0, pen_y_ff} + (CW+1)'(row_off_ff);
   assign sum_adv  = {1'b0, pen_x_ff} + (CW+1)'(advance);

   always_comb begin
      state_in      = state_ff;
      scale_in      = scale_ff;
      pen_valid_in  = pen_valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      dot_x_in      = dot_x_ff;
      dot_y_in      = dot_y_ff;
      dot_colour_in = dot_colour_ff;
      last_dot_in   = last_dot_ff;
      glyph_in      = glyph_ff;
      colour_in     = colour_ff;
      sos_in        = sos_ff;
      text_x_in     = text_x_ff;
      text_y_in     = text_y_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      idx_in        = idx_ff;
      row_in        = row_ff;
      col_off_in    = col_off_ff;
      row_off_in    = row_off_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = gdg_pkg::PEN_X_ADDR;
      ram_wr_data   = pen_x_ff;
      ram_rd_addr   = gdg_pkg::PEN_X_ADDR;

      if (csr_valid) begin
         scale_in = csr_data;
      end
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         gdg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               glyph_in  = gdg_pkg::glyph_lookup(req_tdata[gdg_pkg::CODE_W-1:0]);
               text_x_in = req_tdata[gdg_pkg::CODE_W +: CW];
               text_y_in = req_tdata[gdg_pkg::CODE_W+CW +: CW];
               colour_in = req_tdata[gdg_pkg::CODE_W+2*CW +: gdg_pkg::COLOUR_W];
               sos_in    = req_tuser;
               state_in  = gdg_pkg::ST_LOAD_X;
            end
         end
         gdg_pkg::ST_LOAD_X: begin
            ram_rd_addr = gdg_pkg::PEN_Y_ADDR;
            if (sos_ff) begin
               pen_x_in = text_x_ff;
            end else if (pen_valid_ff[gdg_pkg::PEN_X_ADDR]) begin
               pen_x_in = ram_rd_data;
            end else begin
               pen_x_in = '0;
            end
            state_in = gdg_pkg::ST_LOAD_Y;
         end
         gdg_pkg::ST_LOAD_Y: begin
            if (sos_ff) begin
               pen_y_in = text_y_ff;
            end else if (pen_valid_ff[gdg_pkg::PEN_Y_ADDR]) begin
               pen_y_in = ram_rd_data;
            end else begin
               pen_y_in = '0;
            end
            ram_wr_en    = 1'b1;
            ram_wr_addr  = gdg_pkg::PEN_Y_ADDR;
            ram_wr_data  = pen_y_in;
            pen_valid_in[gdg_pkg::PEN_Y_ADDR] = 1'b1;
            idx_in       = '0;
            row_in       = '0;
            col_off_in   = '0;
            row_off_in   = '0;
            state_in     = (glyph_ff == '0) ? gdg_pkg::ST_ADVANCE : gdg_pkg::ST_DRAW;
         end
         gdg_pkg::ST_DRAW: begin
            if (!lit || out_free) begin
               if (lit) begin
                  rsp_tvalid_in = 1'b1;
                  dot_x_in      = sum_x[CW] ? '1 : sum_x[CW-1:0];
                  dot_y_in      = sum_y[CW] ? '1 : sum_y[CW-1:0];
                  dot_colour_in = colour_ff;
                  last_dot_in   = last;
               end
               if (row_ff == gdg_pkg::ROW_W'(gdg_pkg::GLYPH_ROWS - 1)) begin
                  row_in     = '0;
                  row_off_in = '0;
                  col_off_in = col_off_ff + OW'(scale);
               end else begin
                  row_in     = row_ff + 1'b1;
                  row_off_in = row_off_ff + OW'(scale);
               end
               idx_in = idx_ff + 1'b1;
               if ((lit && last) ||
                   idx_ff == gdg_pkg::IDX_W'(gdg_pkg::DOT_COUNT - 1)) begin
                  state_in = gdg_pkg::ST_ADVANCE;
               end
            end
         end
         gdg_pkg::ST_ADVANCE: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = gdg_pkg::PEN_X_ADDR;
            ram_wr_data  = sum_adv[CW] ? '1 : sum_adv[CW-1:0];
            pen_valid_in[gdg_pkg::PEN_X_ADDR] = 1'b1;
            state_in     = gdg_pkg::ST_IDLE;
         end
         default: begin
            state_in = gdg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gdg_pkg::ST_IDLE;
         scale_ff      <= gdg_pkg::SCALE_RESET;
         pen_valid_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         pen_valid_ff  <= pen_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      dot_x_ff      <= dot_x_in;
      dot_y_ff      <= dot_y_in;
      dot_colour_ff <= dot_colour_in;
      last_dot_ff   <= last_dot_in;
      glyph_ff      <= glyph_in;
      colour_ff     <= colour_in;
      sos_ff        <= sos_in;
      text_x_ff     <= text_x_in;
      text_y_ff     <= text_y_in;
      pen_x_ff      <= pen_x_in;
      pen_y_ff      <= pen_y_in;
      idx_ff        <= idx_in;
      row_ff        <= row_in;
      col_off_ff    <= col_off_in;
      row_off_ff    <= row_off_in;
   end

endmodule

// File: tb/tb_glyph_dot_generator_5x7.sv
// Self-checking testbench for glyph_dot_generator_5x7: renders characters with random
// pacing on both streams and checks every dot against a local glyph renderer.
// Depends on gdg_pkg and glyph_dot_generator_5x7.

module tb_glyph_dot_generator_5x7;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COORD_MAX    = 65535;
   localparam int          QUIET_CYCLES = 50;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          STRING_ITEMS = 47;
   localparam int          PHASES       = 8;
   localparam string       GLYPH_SET    = " !-./0123456789:ABCDEFGHIJKLMNOPQRSTUVWXYZ";

   // column bytes c0..c4 from the high byte down, bit 0 = top row
   localparam logic [39:0] FONT [0:41] = '{
      40'h0000000000, 40'h00005F0000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946,
      40'h2141454B31, 40'h1814127F10, 40'h2745454539, 40'h3C4A494930,
      40'h0171090503, 40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
      40'h7F49494941, 40'h7F09090101, 40'h3E4149497A, 40'h7F0808087F,
      40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
      40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
      40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
      40'h0304780403, 40'h6151494543
   };

   typedef struct packed {
      logic [gdg_pkg::COORD_W-1:0]  x;
      logic [gdg_pkg::COORD_W-1:0]  y;
      logic [gdg_pkg::COLOUR_W-1:0] colour;
      logic                         last;
   } glyph_dot_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [gdg_pkg::SCALE_W-1:0]      csr_data   = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // char_code, text_x, text_y, ink_colour
   logic [gdg_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             req_tuser  = 1'b0; // start_of_string
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [gdg_pkg::RSP_DATA_W-1:0]   rsp_tdata;         // dot_x, dot_y, dot_colour
   logic                             rsp_tlast;         // last_dot

   glyph_dot_type                 expected_dots [$];
   logic [gdg_pkg::SCALE_W-1:0]   dot_scale = gdg_pkg::SCALE_RESET;
   logic [gdg_pkg::COORD_W-1:0]   pen_x = '0;
   logic [gdg_pkg::COORD_W-1:0]   pen_y = '0;
   int                            mismatch_count = 0;
   int                            quiet_count = 0;
   bit                            req_idle_on = 1'b1;
   bit                            rsp_stall_on = 1'b1;

   glyph_dot_generator_5x7 DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [gdg_pkg::COORD_W-1:0] clamp_coord(input int unsigned v);
      return (v > COORD_MAX) ? gdg_pkg::COORD_W'(COORD_MAX) : gdg_pkg::COORD_W'(v);
   endfunction

   function automatic int glyph_slot(input logic [gdg_pkg::CODE_W-1:0] code);
      logic [gdg_pkg::CODE_W-1:0] c;
      c = code;
      if (c >= "a" && c <= "z") begin
         c = c - 8'h20;
      end
      for (int k = 0; k < GLYPH_SET.len(); k++) begin
         if (GLYPH_SET[k] == c) begin
            return k;
         end
      end
      return -1;
   endfunction

   function automatic void predict_glyph(input logic [gdg_pkg::CODE_W-1:0] code,
                                         input logic sos,
                                         input logic [gdg_pkg::COORD_W-1:0] tx,
                                         input logic [gdg_pkg::COORD_W-1:0] ty,
                                         input logic [gdg_pkg::COLOUR_W-1:0] ink);
      int unsigned   pitch;
      int            slot;
      logic [7:0]    bits;
      glyph_dot_type dots [$];
      glyph_dot_type d;
      pitch = (dot_scale < gdg_pkg::SCALE_MIN) ? gdg_pkg::SCALE_MIN :
              (dot_scale > gdg_pkg::SCALE_MAX) ? gdg_pkg::SCALE_MAX : dot_scale;
      if (sos) begin
         pen_x = tx;
         pen_y = ty;
      end
      slot = glyph_slot(code);
      if (slot >= 0) begin
         for (int col = 0; col < gdg_pkg::GLYPH_COLUMNS; col++) begin
            bits = FONT[slot][(4 - col) * 8 +: 8];
            for (int row = 0; row < gdg_pkg::GLYPH_ROWS; row++) begin
               if (bits[row]) begin
                  d.x      = clamp_coord(pen_x + col * pitch);
                  d.y      = clamp_coord(pen_y + row * pitch);
                  d.colour = ink;
                  d.last   = 1'b0;
                  dots.push_back(d);
               end
            end
         end
         if (dots.size() > 0) begin
            dots[dots.size() - 1].last = 1'b1;
         end
      end
      foreach (dots[i]) begin
         expected_dots.push_back(dots[i]);
      end
      pen_x = clamp_coord(pen_x + gdg_pkg::CELL_ADVANCE * pitch);
   endfunction

   task automatic send_char(input logic [gdg_pkg::CODE_W-1:0] code, input logic sos,
                            input logic [gdg_pkg::COORD_W-1:0] tx,
                            input logic [gdg_pkg::COORD_W-1:0] ty,
                            input logic [gdg_pkg::COLOUR_W-1:0] ink);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ink, ty, tx, code};
      req_tuser  <= sos;
      do @(posedge clock); while (!req_tready);
      predict_glyph(code, sos, tx, ty, ink);
   endtask

   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (expected_dots.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_dot_scale(input logic [gdg_pkg::SCALE_W-1:0] value);
      wait_for_quiet();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      dot_scale = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [gdg_pkg::COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 3))
         0:       return gdg_pkg::COORD_W'($urandom_range(0, 255));
         1:       return gdg_pkg::COORD_W'($urandom_range(65000, 65535));
         default: return gdg_pkg::COORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [gdg_pkg::CODE_W-1:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r <= 5) begin
         return GLYPH_SET[$urandom_range(0, GLYPH_SET.len() - 1)];
      end else if (r <= 7) begin
         return gdg_pkg::CODE_W'("a" + $urandom_range(0, 25));
      end
      return gdg_pkg::CODE_W'($urandom_range(0, 255));
   endfunction

   task automatic test_glyph_set();
      logic [gdg_pkg::CODE_W-1:0] codes [$];
      codes = '{"!", "-", ".", "/", "0", "9", ":", "A", "Z", "a", "z", "W", "8",
                " ", 8'h00, 8'h7F, 8'h80, 8'hFF};
      foreach (codes[i]) begin
         send_char(codes[i], i == 0, 16'd10, 16'd20,
                   i[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
      end
   endtask

   task automatic test_coordinate_saturation();
      write_dot_scale(5'd31);
      send_char("M", 1'b1, 16'd65500, 16'd65500, 32'hA5A5_5A5A);
      send_char("8", 1'b0, 16'd0, 16'd0, 32'h5A5A_A5A5);
      send_char("H", 1'b0, 16'd0, 16'd0, 32'h1234_5678);
      send_char("X", 1'b1, 16'hFFFF, 16'hFFFF, 32'h0);
   endtask

   task automatic test_scale_limits();
      write_dot_scale(5'd0);
      send_char("8", 1'b1, 16'd0, 16'd0, 32'hFFFF_FFFF);
      write_dot_scale(gdg_pkg::SCALE_MIN);
      send_char("W", 1'b0, 16'd0, 16'd0, 32'h8000_0001);
      write_dot_scale(gdg_pkg::SCALE_MAX);
      send_char("m", 1'b1, 16'd300, 16'd400, 32'h0F0F_0F0F);
      write_dot_scale(5'd17);
      send_char("Q", 1'b0, 16'd0, 16'd0, 32'hF0F0_F0F0);
   endtask

   task automatic test_random_strings();
      int          sent;
      int unsigned len;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_dot_scale(phase == 0 ? gdg_pkg::SCALE_MIN :
                         phase == 1 ? gdg_pkg::SCALE_MAX :
                         gdg_pkg::SCALE_W'($urandom_range(0, 31)));
         req_idle_on  = phase[0];
         rsp_stall_on = phase[1];
         sent = 0;
         while (sent < STRING_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
               send_char(gdg_pkg::CODE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)),
                         gdg_pkg::COORD_W'($urandom_range(0, 65535)),
                         gdg_pkg::COORD_W'($urandom_range(0, 65535)), $urandom);
               sent++;
            end else begin
               len = $urandom_range(1, 12);
               send_char(pick_char(), 1'b1, pick_coord(), pick_coord(), $urandom);
               for (int i = 1; i < len; i++) begin
                  send_char(pick_char(), 1'b0, gdg_pkg::COORD_W'($urandom),
                            gdg_pkg::COORD_W'($urandom), $urandom);
               end
               sent += len;
            end
         end
      end
   endtask

   initial begin
      glyph_dot_type got;
      glyph_dot_type want;
      int unsigned   stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_stall_on ? $urandom_range(0, 14) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tdata[gdg_pkg::COORD_W-1:0],
                rsp_tdata[2*gdg_pkg::COORD_W-1:gdg_pkg::COORD_W],
                rsp_tdata[gdg_pkg::RSP_DATA_W-1:2*gdg_pkg::COORD_W], rsp_tlast};
         if (expected_dots.size() == 0) begin
            $display("%0t: unexpected dot x=%0d y=%0d colour=%h last=%b",
                     $time, got.x, got.y, got.colour, got.last);
            mismatch_count++;
         end else begin
            want = expected_dots.pop_front();
            if (got !== want) begin
               $display({"%0t: expected x=%0d y=%0d colour=%h last=%b, ",
                         "got x=%0d y=%0d colour=%h last=%b"},
                        $time, want.x, want.y, want.colour, want.last,
                        got.x, got.y, got.colour, got.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_count);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_glyph_set();
      test_coordinate_saturation();
      test_scale_limits();
      test_random_strings();
      wait_for_quiet();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
